// ===== rtl/core/croa_pkg.sv =====
package croa_pkg;

  typedef enum logic [4:0] {
    CMD_NOP = 5'd0,
    CMD_LDA = 5'd1,
    CMD_LDX = 5'd2,
    CMD_LDY = 5'd3,
    CMD_EOR = 5'd4,
    CMD_AND = 5'd5,
    CMD_ORA = 5'd6,
    CMD_ADC = 5'd7,
    CMD_SBC = 5'd8,
    CMD_CMP = 5'd9,
    CMD_CPX = 5'd10,
    CMD_CPY = 5'd11,
    CMD_BIT = 5'd12,
    CMD_LAX = 5'd13,
    CMD_ARR = 5'd14,
    CMD_AXS = 5'd15,
    CMD_ALR = 5'd16,
    CMD_XAA = 5'd17,
    CMD_OAL = 5'd18
  } cmd_t;

  // Bits the unstable XAA/OAL combinations force high in A before the AND.
  localparam logic [7:0] MAGIC_MASK = 8'hEE;

endpackage

// ===== rtl/core/cpu_read_op_alu.sv =====
// An accepted start reaches the done strobe through the input register,
//   then the result register.
// Throughput: one transaction per cycle; busy is low except during reset.
// The receiver cannot stall: each result is marked by done, high for a single
//   cycle, and stays on the result ports until the next result.
// Reset (rst, synchronous, active high): drop any transaction in flight.
module cpu_read_op_alu (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] command,
  input  logic [7:0] operand,
  input  logic [7:0] acc_in,
  input  logic [7:0] xreg_in,
  input  logic [7:0] yreg_in,
  input  logic       carry_in,
  input  logic       zero_in,
  input  logic       overflow_in,
  input  logic       sign_in,
  output logic       done,
  output logic [7:0] acc_out,
  output logic [7:0] xreg_out,
  output logic [7:0] yreg_out,
  output logic       carry_out,
  output logic       zero_out,
  output logic       overflow_out,
  output logic       sign_out
);

  // Input register: one transaction in flight per stage.
  logic       valid_q;
  logic [4:0] cmd_q;
  logic [7:0] m_q, a_q, x_q, y_q;
  logic       c_q, z_q, v_q, n_q;

  // Combinational results
  logic [7:0] a_next, x_next, y_next;
  logic       c_next, z_next, v_next, n_next;
  logic [7:0] res;
  logic       set_nz;

  // Shared 9-bit adder: add, subtract and compare all run through it.
  logic [7:0] add_lhs, add_rhs;
  logic       add_cin;
  logic [8:0] add_sum;
  logic [7:0] and_am;
  logic [7:0] arr_val;

  logic accept;

  // Busy only in reset; in any other cycle a start is accepted.
  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  // Payload capture: hold when no transaction arrives.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      m_q   <= operand;
      a_q   <= acc_in;
      x_q   <= xreg_in;
      y_q   <= yreg_in;
      c_q   <= carry_in;
      z_q   <= zero_in;
      v_q   <= overflow_in;
      n_q   <= sign_in;
    end
  end

  assign and_am  = a_q & m_q;
  assign arr_val = {c_q, and_am[7:1]};

  // Adder operand selection. Subtract-like commands invert M; compares and
  // AXS force the carry in to 1 so the carry out reads as "lhs >= M".
  always_comb begin
    add_lhs = a_q;
    add_rhs = ~m_q;
    add_cin = 1'b1;
    case (croa_pkg::cmd_t'(cmd_q))
      croa_pkg::CMD_ADC: begin
        add_rhs = m_q;
        add_cin = c_q;
      end
      croa_pkg::CMD_SBC: begin
        add_cin = c_q;
      end
      croa_pkg::CMD_CPX: begin
        add_lhs = x_q;
      end
      croa_pkg::CMD_CPY: begin
        add_lhs = y_q;
      end
      croa_pkg::CMD_AXS: begin
        add_lhs = a_q & x_q;
      end
      default: begin
        add_lhs = a_q;
      end
    endcase
  end

  assign add_sum = {1'b0, add_lhs} + {1'b0, add_rhs} + {8'd0, add_cin};

  // Operation decode; untouched registers and flags pass through.
  always_comb begin
    a_next = a_q;
    x_next = x_q;
    y_next = y_q;
    c_next = c_q;
    z_next = z_q;
    v_next = v_q;
    n_next = n_q;
    res    = 8'd0;
    set_nz = 1'b1;
    case (croa_pkg::cmd_t'(cmd_q))
      croa_pkg::CMD_LDA: begin
        a_next = m_q;
        res    = m_q;
      end
      croa_pkg::CMD_LDX: begin
        x_next = m_q;
        res    = m_q;
      end
      croa_pkg::CMD_LDY: begin
        y_next = m_q;
        res    = m_q;
      end
      croa_pkg::CMD_EOR: begin
        a_next = a_q ^ m_q;
        res    = a_q ^ m_q;
      end
      croa_pkg::CMD_AND: begin
        a_next = and_am;
        res    = and_am;
      end
      croa_pkg::CMD_ORA: begin
        a_next = a_q | m_q;
        res    = a_q | m_q;
      end
      croa_pkg::CMD_ADC: begin
        a_next = add_sum[7:0];
        res    = add_sum[7:0];
        c_next = add_sum[8];
        v_next = ~(a_q[7] ^ m_q[7]) & (a_q[7] ^ add_sum[7]);
      end
      croa_pkg::CMD_SBC: begin
        a_next = add_sum[7:0];
        res    = add_sum[7:0];
        c_next = add_sum[8];
        v_next = (a_q[7] ^ m_q[7]) & (a_q[7] ^ add_sum[7]);
      end
      croa_pkg::CMD_CMP, croa_pkg::CMD_CPX, croa_pkg::CMD_CPY: begin
        res    = add_sum[7:0];
        c_next = add_sum[8];
      end
      croa_pkg::CMD_BIT: begin
        set_nz = 1'b0;
        n_next = m_q[7];
        v_next = m_q[6];
        z_next = (and_am == 8'd0);
      end
      croa_pkg::CMD_LAX: begin
        a_next = m_q;
        x_next = m_q;
        res    = m_q;
      end
      croa_pkg::CMD_ARR: begin
        a_next = arr_val;
        res    = arr_val;
        c_next = arr_val[6];
        v_next = arr_val[6] ^ arr_val[5];
      end
      croa_pkg::CMD_AXS: begin
        x_next = add_sum[7:0];
        res    = add_sum[7:0];
        c_next = add_sum[8];
      end
      croa_pkg::CMD_ALR: begin
        a_next = {1'b0, and_am[7:1]};
        res    = {1'b0, and_am[7:1]};
        c_next = and_am[0];
      end
      croa_pkg::CMD_XAA: begin
        a_next = (a_q | croa_pkg::MAGIC_MASK) & x_q & m_q;
        res    = (a_q | croa_pkg::MAGIC_MASK) & x_q & m_q;
      end
      croa_pkg::CMD_OAL: begin
        a_next = (a_q | croa_pkg::MAGIC_MASK) & m_q;
        x_next = (a_q | croa_pkg::MAGIC_MASK) & m_q;
        res    = (a_q | croa_pkg::MAGIC_MASK) & m_q;
      end
      default: begin
        // NOP and unused codes: everything passes through.
        set_nz = 1'b0;
      end
    endcase
    if (set_nz) begin
      n_next = res[7];
      z_next = (res == 8'd0);
    end
  end

  // Result register: the strobe lasts exactly one cycle per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_q) begin
      acc_out      <= a_next;
      xreg_out     <= x_next;
      yreg_out     <= y_next;
      carry_out    <= c_next;
      zero_out     <= z_next;
      overflow_out <= v_next;
      sign_out     <= n_next;
    end
  end

endmodule

// ===== rtl/core/croa_checker.sv =====
module croa_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [4:0] command,
  input logic [7:0] operand,
  input logic [7:0] acc_in,
  input logic [7:0] yreg_in,
  input logic       done,
  input logic [7:0] acc_out,
  input logic [7:0] yreg_out,
  input logic       sign_out
);

  // Every accepted transaction yields a done strobe.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("done missing two cycles after accepted start");

  // No strobe without an earlier accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !$past(start && !busy, 2) |-> !done)
    else $error("done without an accepted transaction");

  // Reset drops anything in flight.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done asserted right after reset");

  // A load to A returns the operand and its sign.
  a_lda_value: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == croa_pkg::CMD_LDA) |-> ##2
      (acc_out == $past(operand, 2) && sign_out == $past(operand[7], 2)))
    else $error("LDA result mismatch");

  // A no-op leaves A and Y as they came in.
  a_nop_pass: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == croa_pkg::CMD_NOP) |-> ##2
      (acc_out == $past(acc_in, 2) && yreg_out == $past(yreg_in, 2)))
    else $error("NOP changed a register");

endmodule

bind cpu_read_op_alu croa_checker u_croa_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .command  (command),
  .operand  (operand),
  .acc_in   (acc_in),
  .yreg_in  (yreg_in),
  .done     (done),
  .acc_out  (acc_out),
  .yreg_out (yreg_out),
  .sign_out (sign_out)
);
